// File: sv/pdrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_pkg
// Shared constants, codes and types of the packet descriptor ring channel.
// ----------------------------------------------------------------------------
package pdrc_pkg;

	localparam int RING_DEPTH   = 16;
	localparam int BUFFER_BYTES = 4096;

	localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int BPTR_W = $clog2(BUFFER_BYTES);
	localparam int FREE_W = BPTR_W + 1;

	localparam int CMD_W  = 2;
	localparam int LEN_W  = 13;
	localparam int OFFS_W = 12;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PULL    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO_LEN = 2'd3;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic              side;
		logic [OFFS_W-1:0] offset;
	} desc_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_t;

	typedef struct packed {
		logic busy;
	} ctl_status_t;

endpackage
`default_nettype wire

// File: sv/pdrc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_if
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdrc_req_if;
	import pdrc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [LEN_W-1:0]  packet_length;
	logic              packet_side;
	logic [OFFS_W-1:0] payload_offset;
	logic [OFFS_W-1:0] read_advance;

	modport source (output valid, command, packet_length, packet_side, payload_offset,
		read_advance, input ready);
	modport sink (input valid, command, packet_length, packet_side, payload_offset,
		read_advance, output ready);
endinterface

interface pdrc_rsp_if;
	import pdrc_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              desc_valid;
	logic [LEN_W-1:0]  desc_length;
	logic              desc_side;
	logic [OFFS_W-1:0] desc_offset;
	logic [OFFS_W-1:0] byte_read_offset;
	logic [LEN_W-1:0]  free_bytes;

	modport source (output valid, status, desc_valid, desc_length, desc_side, desc_offset,
		byte_read_offset, free_bytes, input ready);
	modport sink (input valid, status, desc_valid, desc_length, desc_side, desc_offset,
		byte_read_offset, free_bytes, output ready);
endinterface
`default_nettype wire

// File: sv/pdrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_ctrl
// Sequencer: takes one command beat, executes it, holds the result beat.
// ----------------------------------------------------------------------------
module pdrc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	output pdrc_pkg::ctl_t        ctl
);
	import pdrc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign ctl.capture = in_valid && in_ready;
	assign ctl.commit  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (ctl.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/pdrc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_dp
// Descriptor store, slot valid bits, ring heads, byte pointers, result register.
// ----------------------------------------------------------------------------
module pdrc_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pdrc_pkg::ctl_t               ctl,
	input  wire [pdrc_pkg::CMD_W-1:0]    command,
	input  wire [pdrc_pkg::LEN_W-1:0]    packet_length,
	input  wire                          packet_side,
	input  wire [pdrc_pkg::OFFS_W-1:0]   payload_offset,
	input  wire [pdrc_pkg::OFFS_W-1:0]   read_advance,
	output logic [pdrc_pkg::STAT_W-1:0]  status,
	output logic                         desc_valid,
	output logic [pdrc_pkg::LEN_W-1:0]   desc_length,
	output logic                         desc_side,
	output logic [pdrc_pkg::OFFS_W-1:0]  desc_offset,
	output logic [pdrc_pkg::OFFS_W-1:0]  byte_read_offset,
	output logic [pdrc_pkg::LEN_W-1:0]   free_bytes
);
	import pdrc_pkg::*;

	desc_t mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] slot_valid_q;
	logic [HEAD_W-1:0] wr_head_q;
	logic [HEAD_W-1:0] rd_head_q;
	logic [BPTR_W-1:0] wptr_q;
	logic [BPTR_W-1:0] rptr_q;

	logic [CMD_W-1:0]  cmd_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              side_s1;
	logic [OFFS_W-1:0] offs_s1;
	logic [OFFS_W-1:0] adv_s1;
	desc_t             rd_desc_s1;

	logic              do_push;
	logic              do_pull;
	logic [STAT_W-1:0] status_d;
	logic [BPTR_W-1:0] wptr_d;
	logic [BPTR_W-1:0] rptr_d;
	logic [FREE_W-1:0] free_d;

	logic [STAT_W-1:0] status_q;
	logic              dvalid_q;
	desc_t             desc_q;
	logic [BPTR_W-1:0] rdoff_q;
	logic [FREE_W-1:0] free_q;

	function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
		if (h == HEAD_W'(RING_DEPTH - 1)) begin
			return '0;
		end
		return h + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1     <= command;
			len_s1     <= packet_length;
			side_s1    <= packet_side;
			offs_s1    <= payload_offset;
			adv_s1     <= read_advance;
			rd_desc_s1 <= mem[rd_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_head_q] <= '{length: len_s1, side: side_s1, offset: offs_s1};
		end
	end

	always_comb begin
		do_push  = 1'b0;
		do_pull  = 1'b0;
		status_d = STAT_OK;
		wptr_d   = wptr_q;
		rptr_d   = rptr_q;
		case (cmd_s1)
			CMD_PUSH: begin
				if (len_s1 == '0) begin
					status_d = STAT_ZERO_LEN;
				end else if (slot_valid_q[wr_head_q]) begin
					status_d = STAT_FULL;
				end else begin
					do_push = ctl.commit;
					wptr_d  = wptr_q + len_s1[BPTR_W-1:0];
				end
			end
			CMD_PULL: begin
				if (slot_valid_q[rd_head_q]) begin
					do_pull = ctl.commit;
				end else begin
					status_d = STAT_EMPTY;
				end
			end
			CMD_ADVANCE: begin
				rptr_d = rptr_q + adv_s1[BPTR_W-1:0];
			end
			default: status_d = STAT_OK;
		endcase
		if (rptr_d <= wptr_d) begin
			free_d = FREE_W'(BUFFER_BYTES) - {1'b0, wptr_d};
		end else begin
			free_d = {1'b0, rptr_d} - {1'b0, wptr_d} - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			wr_head_q    <= '0;
			rd_head_q    <= '0;
			wptr_q       <= '0;
			rptr_q       <= '0;
		end else if (ctl.commit) begin
			wptr_q <= wptr_d;
			rptr_q <= rptr_d;
			if (do_push) begin
				slot_valid_q[wr_head_q] <= 1'b1;
				wr_head_q               <= head_inc(wr_head_q);
			end
			if (do_pull) begin
				slot_valid_q[rd_head_q] <= 1'b0;
				rd_head_q               <= head_inc(rd_head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_d;
			dvalid_q <= do_pull;
			desc_q   <= do_pull ? rd_desc_s1 : '0;
			rdoff_q  <= rptr_d;
			free_q   <= free_d;
		end
	end

	assign status           = status_q;
	assign desc_valid       = dvalid_q;
	assign desc_length      = desc_q.length;
	assign desc_side        = desc_q.side;
	assign desc_offset      = desc_q.offset;
	assign byte_read_offset = OFFS_W'(rdoff_q);
	assign free_bytes       = LEN_W'(free_q);
endmodule
`default_nettype wire

// File: sv/packet_descriptor_ring_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_descriptor_ring_channel
// One channel of a packet hand-off engine: descriptor ring plus byte ring
// read and write pointers, driven by push, pull and advance commands.
// ----------------------------------------------------------------------------
// each command is captured, then executed; its result is registered at commit
// commit waits for a held result beat; no new command is taken until it is done
// a new command is taken while the previous result beat still waits
// reset clears slot valid bits, ring heads and byte pointers at once
// descriptor store has no reset, entries are read only after being written
module packet_descriptor_ring_channel (
	input  wire        clk,
	input  wire        arst_n,
	pdrc_req_if.sink   req,
	pdrc_rsp_if.source rsp
);
	import pdrc_pkg::*;

	ctl_t        ctl;

	pdrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.ctl      (ctl)
	);

	pdrc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.command         (req.command),
		.packet_length   (req.packet_length),
		.packet_side     (req.packet_side),
		.payload_offset  (req.payload_offset),
		.read_advance    (req.read_advance),
		.status          (rsp.status),
		.desc_valid      (rsp.desc_valid),
		.desc_length     (rsp.desc_length),
		.desc_side       (rsp.desc_side),
		.desc_offset     (rsp.desc_offset),
		.byte_read_offset(rsp.byte_read_offset),
		.free_bytes      (rsp.free_bytes)
	);
endmodule
`default_nettype wire

// File: sv/pdrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_checker
// Port-level checks of the channel, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pdrc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire [pdrc_pkg::STAT_W-1:0]   rsp_status,
	input wire                          rsp_desc_valid,
	input wire [pdrc_pkg::LEN_W-1:0]    rsp_desc_length,
	input wire [pdrc_pkg::OFFS_W-1:0]   rsp_byte_read_offset,
	input wire [pdrc_pkg::LEN_W-1:0]    rsp_free_bytes
);
	import pdrc_pkg::*;

	logic req_beat;

	assign req_beat = req_valid && req_ready;

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req_ready)
		else $error("command beat accepted in consecutive cycles");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_byte_read_offset) && $stable(rsp_free_bytes))
		else $error("stalled result beat changed");

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_beat, 2))
		else $error("result beat without a command beat two cycles earlier");

	a_pull_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_desc_valid |-> rsp_status == STAT_OK && rsp_desc_length != '0)
		else $error("pulled descriptor with bad status or zero length");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_bytes <= LEN_W'(BUFFER_BYTES))
		else $error("free byte count above buffer size");
endmodule

bind packet_descriptor_ring_channel pdrc_checker u_pdrc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_desc_valid      (rsp.desc_valid),
	.rsp_desc_length     (rsp.desc_length),
	.rsp_byte_read_offset(rsp.byte_read_offset),
	.rsp_free_bytes      (rsp.free_bytes)
);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the packet descriptor ring channel: a queue-fed driver sends push,
// pull and advance commands, a clocked monitor compares every result beat
// with a cycle-free model of the descriptor ring and byte pointers.
// ----------------------------------------------------------------------------
module testbench;
	import pdrc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int PHASE_ITEMS = 475;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [LEN_W-1:0]  length;
		logic              side;
		logic [OFFS_W-1:0] offset;
		logic [OFFS_W-1:0] advance;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              desc_valid;
		logic [LEN_W-1:0]  desc_length;
		logic              desc_side;
		logic [OFFS_W-1:0] desc_offset;
		logic [OFFS_W-1:0] byte_read_offset;
		logic [LEN_W-1:0]  free_bytes;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	pdrc_req_if req_ch ();
	pdrc_rsp_if rsp_ch ();

	packet_descriptor_ring_channel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// ring model state
	logic              slot_busy [RING_DEPTH];
	desc_t             slot_desc [RING_DEPTH];
	logic [HEAD_W-1:0] wr_head;
	logic [HEAD_W-1:0] rd_head;
	logic [BPTR_W-1:0] byte_wr;
	logic [BPTR_W-1:0] byte_rd;

	cmd_t pending_cmds [$];
	rsp_t expected_rsps [$];
	cmd_t drive_item;
	rsp_t want_rsp;
	rsp_t seen_rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_stored = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_zero = 0;
	int n_pulled = 0;
	int n_advance = 0;
	int n_unknown = 0;

	function automatic rsp_t channel_apply(input cmd_t c);
		rsp_t r;
		r = '0;
		case (c.command)
			CMD_PUSH: begin
				if (c.length == '0) begin
					r.status = STAT_ZERO_LEN;
					n_zero++;
				end else if (slot_busy[wr_head]) begin
					r.status = STAT_FULL;
					n_full++;
				end else begin
					slot_busy[wr_head] = 1'b1;
					slot_desc[wr_head] = '{length: c.length, side: c.side, offset: c.offset};
					wr_head = wr_head + 1'b1;
					byte_wr = BPTR_W'(byte_wr + c.length);
					n_stored++;
				end
			end
			CMD_PULL: begin
				if (slot_busy[rd_head]) begin
					r.desc_valid = 1'b1;
					r.desc_length = slot_desc[rd_head].length;
					r.desc_side = slot_desc[rd_head].side;
					r.desc_offset = slot_desc[rd_head].offset;
					slot_busy[rd_head] = 1'b0;
					rd_head = rd_head + 1'b1;
					n_pulled++;
				end else begin
					r.status = STAT_EMPTY;
					n_empty++;
				end
			end
			CMD_ADVANCE: begin
				byte_rd = BPTR_W'(byte_rd + c.advance);
				n_advance++;
			end
			default: begin
				n_unknown++;
			end
		endcase
		r.byte_read_offset = byte_rd;
		if (byte_rd <= byte_wr)
			r.free_bytes = LEN_W'(BUFFER_BYTES) - LEN_W'(byte_wr);
		else
			r.free_bytes = LEN_W'(byte_rd) - LEN_W'(byte_wr) - 1'b1;
		return r;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] command, input int length, input int side,
			input int offset, input int advance);
		cmd_t c;
		c.command = command;
		c.length = LEN_W'(length);
		c.side = side[0];
		c.offset = OFFS_W'(offset);
		c.advance = OFFS_W'(advance);
		pending_cmds.push_back(c);
		n_queued++;
	endtask

	task automatic queue_random(input int count);
		int push_pct;
		int roll;
		int length;
		int advance;
		logic [CMD_W-1:0] command;
		push_pct = 45;
		for (int i = 0; i < count; i++) begin
			// bias toward filling or draining the ring in stretches
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 70;
					1: push_pct = 25;
					default: push_pct = 45;
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				command = CMD_UNKNOWN;
			else if (roll < push_pct)
				command = CMD_PUSH;
			else if ($urandom_range(0, 2) != 0)
				command = CMD_PULL;
			else
				command = CMD_ADVANCE;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				length = 0;
			else if (roll < 10)
				length = $urandom_range(4097, 8191);
			else if (roll < 30)
				length = $urandom_range(1, 64);
			else
				length = $urandom_range(1, 4096);
			roll = $urandom_range(0, 99);
			if (roll < 10)
				advance = 0;
			else if (roll < 40)
				advance = $urandom_range(1, 256);
			else
				advance = $urandom_range(0, 4095);
			queue_cmd(command, length, $urandom_range(0, 1), $urandom_range(0, 4095), advance);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s expected %0d got %0d", name, want_v, got_v);
			n_errors++;
		end
	endtask

	// driver: models the command at the beat it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= '0;
			req_ch.packet_length <= '0;
			req_ch.packet_side <= 1'b0;
			req_ch.payload_offset <= '0;
			req_ch.read_advance <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(channel_apply(drive_item));
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drive_item = pending_cmds.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= drive_item.command;
					req_ch.packet_length <= drive_item.length;
					req_ch.packet_side <= drive_item.side;
					req_ch.payload_offset <= drive_item.offset;
					req_ch.read_advance <= drive_item.advance;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: result beats against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result beat with no command outstanding");
					n_errors++;
				end else begin
					want_rsp = expected_rsps.pop_front();
					seen_rsp = '{rsp_ch.status, rsp_ch.desc_valid, rsp_ch.desc_length,
						rsp_ch.desc_side, rsp_ch.desc_offset, rsp_ch.byte_read_offset,
						rsp_ch.free_bytes};
					check_field("status", want_rsp.status, seen_rsp.status);
					check_field("desc_valid", want_rsp.desc_valid, seen_rsp.desc_valid);
					check_field("desc_length", want_rsp.desc_length, seen_rsp.desc_length);
					check_field("desc_side", want_rsp.desc_side, seen_rsp.desc_side);
					check_field("desc_offset", want_rsp.desc_offset, seen_rsp.desc_offset);
					check_field("byte_read_offset", want_rsp.byte_read_offset,
						seen_rsp.byte_read_offset);
					check_field("free_bytes", want_rsp.free_bytes, seen_rsp.free_bytes);
					n_checked++;
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL packet_descriptor_ring_channel");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = '0;
		req_ch.packet_length = '0;
		req_ch.packet_side = 1'b0;
		req_ch.payload_offset = '0;
		req_ch.read_advance = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			slot_busy[i] = 1'b0;
			slot_desc[i] = '0;
		end
		wr_head = '0;
		rd_head = '0;
		byte_wr = '0;
		byte_rd = '0;

		// directed: empty ring, zero length, extreme lengths and offsets, wraps
		queue_cmd(CMD_PULL, 0, 0, 0, 0);
		queue_cmd(CMD_PUSH, 0, 1, 4095, 4095);
		queue_cmd(CMD_PUSH, 8191, 1, 4095, 4095);
		queue_cmd(CMD_PUSH, 4096, 0, 0, 0);
		queue_cmd(CMD_PUSH, 1, 0, 0, 0);
		queue_cmd(CMD_ADVANCE, 8191, 1, 4095, 4095);
		queue_cmd(CMD_ADVANCE, 0, 0, 0, 0);
		queue_cmd(CMD_UNKNOWN, 8191, 1, 4095, 4095);
		queue_cmd(CMD_PUSH, 2048, 1, 1234, 0);
		queue_cmd(CMD_PULL, 8191, 1, 4095, 4095);
		queue_cmd(CMD_PULL, 0, 0, 0, 0);
		queue_cmd(CMD_ADVANCE, 0, 0, 0, 2);
		queue_cmd(CMD_PULL, 0, 0, 0, 0);
		queue_cmd(CMD_PULL, 0, 0, 0, 0);
		queue_cmd(CMD_PULL, 0, 0, 0, 0);
		queue_cmd(CMD_PUSH, 4095, 0, 1, 0);
		queue_cmd(CMD_ADVANCE, 0, 0, 0, 4094);
		queue_cmd(CMD_PULL, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			queue_random(PHASE_ITEMS);
			while (n_accepted != n_queued) @(posedge clk);
		end

		recv_stall_pct = 0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d commands checked: %0d stored, %0d full, %0d zero length, %0d pulled,",
			n_checked, n_stored, n_full, n_zero, n_pulled);
		$display("%0d pulls on empty ring, %0d advances, %0d unknown commands",
			n_empty, n_advance, n_unknown);
		if (n_errors == 0) begin
			$display("PASS packet_descriptor_ring_channel");
		end else begin
			$display("FAIL packet_descriptor_ring_channel");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/pdrc_pkg.sv
sv/pdrc_if.sv
sv/pdrc_ctrl.sv
sv/pdrc_dp.sv
sv/packet_descriptor_ring_channel.sv
sv/pdrc_checker.sv
sim/testbench.sv
